FILE: rtl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared widths, codes and types of the heightmap triangle height sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

    // Default tile count along one side of the sector.
    localparam int TILES_DEFAULT = 16;

    // Fixed field widths.
    localparam int POS_W    = 32;
    localparam int OFS_W    = POS_W + 1;
    localparam int HEIGHT_W = 24;
    localparam int SHIFT_W  = 5;
    localparam int INDEX_W  = 9;
    localparam int WEIGHT_W = 32;
    localparam int ACC_W    = 60;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_SHIFT = 2'd2;

    localparam logic [SHIFT_W-1:0] TILE_SHIFT_RESET = 5'd10;

    // Operation codes of an input item.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Height reported for a point outside the sector: -999.0 in Q.8.
    localparam logic signed [HEIGHT_W-1:0] OOR_HEIGHT = -24'sd255744;

    // Control of the shared multiply-accumulate unit, set from the sequencer state.
    typedef struct packed {
        logic load;   // take the base corner height, seed the sum
        logic mul;    // multiply weight by (sample - base)
        logic accum;  // add the held product into the sum
    } t_mac_ctrl;

endpackage

`default_nettype wire

FILE: rtl/heightmap_triangle_height_sampler.sv
// ----------------------------------------------------------------------------
// heightmap_triangle_height_sampler
// Terrain sector height sampler: stores a vertex height grid and returns the
// linearly interpolated height of the triangle under a world position.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-------------------------
//  input    | in        | i_in_valid / o_in_ready    | operation, vertex index,
//           |           |                            | height value, query x, z
//  result   | out       | o_out_valid / i_out_ready  | height, in range flag
//  config   | in        | i_cfg_valid / o_cfg_ready  | register index, data
//
// A write item is stored at the clock edge on which it transfers, so writes
// can transfer back to back. A query holds the input off until it finishes:
// S_RANGE checks the range and forms addresses, S_RD_BASE, S_RD_A and S_RD_B
// read the single read port of the vertex memory, S_MUL_B and S_ACC_B pass
// through the one shared multiplier and accumulator, and S_DONE loads the
// output register. A query outside the sector skips the reads and the
// multiply-accumulate steps.
// The result is held in an output register, so a new item is accepted while
// a finished result still waits; a query finishing then waits in S_DONE for
// that slot, and holds the input off, while the slot stays full.
// Reset is synchronous and active low; the vertex memory is not cleared and
// must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_triangle_height_sampler #(
    parameter int TILES_PER_SIDE = hts_pkg::TILES_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_operation,
    input  logic [hts_pkg::INDEX_W-1:0]          i_vertex_index,
    input  logic signed [hts_pkg::HEIGHT_W-1:0]  i_height_value,
    input  logic signed [hts_pkg::POS_W-1:0]     i_query_x,
    input  logic signed [hts_pkg::POS_W-1:0]     i_query_z,

    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [hts_pkg::HEIGHT_W-1:0]  o_height,
    output logic                                 o_in_range,

    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hts_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    import hts_pkg::*;

    localparam int VERTS  = TILES_PER_SIDE + 1;
    localparam int VCOUNT = VERTS * VERTS;
    localparam int AW     = $clog2(VCOUNT);
    localparam int TW     = $clog2(TILES_PER_SIDE + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_RANGE   = 3'd1;
    localparam logic [2:0] S_RD_BASE = 3'd2;
    localparam logic [2:0] S_RD_A    = 3'd3;
    localparam logic [2:0] S_RD_B    = 3'd4;
    localparam logic [2:0] S_MUL_B   = 3'd5;
    localparam logic [2:0] S_ACC_B   = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Configuration registers.
    logic signed [POS_W-1:0] r_origin_x;
    logic signed [POS_W-1:0] r_origin_z;
    logic [SHIFT_W-1:0]      r_tile_shift;

    // Query working registers.
    logic signed [OFS_W-1:0] r_lx;
    logic signed [OFS_W-1:0] r_lz;
    logic                    r_oor;
    logic [AW-1:0]           r_addr_base;
    logic [AW-1:0]           r_addr_a;
    logic [AW-1:0]           r_addr_b;
    logic [WEIGHT_W-1:0]     r_w1;
    logic [WEIGHT_W-1:0]     r_w2;

    // Output register.
    logic                       r_out_valid;
    logic signed [HEIGHT_W-1:0] r_height;
    logic                       r_in_range;

    logic in_xfer;
    logic out_xfer;
    logic out_free;
    logic wr_en;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_height    = r_height;
    assign o_in_range  = r_in_range;

    // ------------------------------------------------------------------
    // Configuration writes. An index past the register list is dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x   <= '0;
            r_origin_z   <= '0;
            r_tile_shift <= TILE_SHIFT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:   r_origin_x   <= $signed(i_cfg_data);
                CFG_ORIGIN_Z:   r_origin_z   <= $signed(i_cfg_data);
                CFG_TILE_SHIFT: r_tile_shift <= i_cfg_data[SHIFT_W-1:0];
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Range check, tile split and corner addressing, used in S_RANGE.
    // The offsets are floored by the tile shift; a negative offset is out
    // of range, so only the logical shift of a nonnegative value matters.
    // ------------------------------------------------------------------
    logic [OFS_W-1:0]    tile_x;
    logic [OFS_W-1:0]    tile_z;
    logic                pos_in_range;
    logic [TW-1:0]       cx;
    logic [TW-1:0]       cz;
    logic [TW-1:0]       col;
    logic [WEIGHT_W-1:0] frac_mask;
    logic [WEIGHT_W-1:0] fx;
    logic [WEIGHT_W-1:0] fz;
    logic [OFS_W-1:0]    edge_len;
    logic [OFS_W-1:0]    frac_sum;
    logic                upper_tri;
    logic [AW-1:0]       row0;
    logic [AW-1:0]       row1;
    logic [AW-1:0]       col_hi_x;
    logic [AW-1:0]       col_lo_x;

    assign tile_x = $unsigned(r_lx) >> r_tile_shift;
    assign tile_z = $unsigned(r_lz) >> r_tile_shift;

    assign pos_in_range = !r_lx[OFS_W-1] && !r_lz[OFS_W-1]
                       && (tile_x < OFS_W'(TILES_PER_SIDE))
                       && (tile_z < OFS_W'(TILES_PER_SIDE));

    assign cx  = tile_x[TW-1:0];
    assign cz  = tile_z[TW-1:0];
    // Grid columns run mirrored in x.
    assign col = TW'(TILES_PER_SIDE - 1) - cx;

    assign frac_mask = (WEIGHT_W'(1) << r_tile_shift) - WEIGHT_W'(1);
    assign fx        = r_lx[WEIGHT_W-1:0] & frac_mask;
    assign fz        = r_lz[WEIGHT_W-1:0] & frac_mask;
    assign edge_len  = OFS_W'(1) << r_tile_shift;
    assign frac_sum  = {1'b0, fx} + {1'b0, fz};
    // A point exactly on the diagonal stays in the low-corner triangle.
    assign upper_tri = frac_sum > edge_len;

    assign row0     = AW'(AW'(cz) * AW'(VERTS));
    assign row1     = row0 + AW'(VERTS);
    assign col_hi_x = AW'(col);
    assign col_lo_x = AW'(col) + AW'(1);

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_lx <= $signed({i_query_x[POS_W-1], i_query_x})
                  - $signed({r_origin_x[POS_W-1], r_origin_x});
            r_lz <= $signed({i_query_z[POS_W-1], i_query_z})
                  - $signed({r_origin_z[POS_W-1], r_origin_z});
        end
        if (r_state == S_RANGE) begin
            r_oor <= !pos_in_range;
            if (upper_tri) begin
                // Seeded from the high-x, high-z corner.
                r_addr_base <= row1 + col_hi_x;
                r_addr_a    <= row1 + col_lo_x;
                r_addr_b    <= row0 + col_hi_x;
                r_w1        <= WEIGHT_W'(edge_len - {1'b0, fx});
                r_w2        <= WEIGHT_W'(edge_len - {1'b0, fz});
            end else begin
                // Seeded from the low-x, low-z corner.
                r_addr_base <= row0 + col_lo_x;
                r_addr_a    <= row0 + col_hi_x;
                r_addr_b    <= row1 + col_lo_x;
                r_w1        <= fx;
                r_w2        <= fz;
            end
        end
    end

    // ------------------------------------------------------------------
    // Vertex memory. Writes land on the transfer edge; grid indexes past
    // the last vertex are dropped.
    // ------------------------------------------------------------------
    logic [AW-1:0]       rd_addr;
    logic [HEIGHT_W-1:0] rd_data;

    assign wr_en = in_xfer && (i_operation == OP_WRITE)
                && ({23'd0, i_vertex_index} < 32'(VCOUNT));

    always_comb begin
        case (r_state)
            S_RD_A:  rd_addr = r_addr_a;
            S_RD_B:  rd_addr = r_addr_b;
            default: rd_addr = r_addr_base;
        endcase
    end

    hts_vram #(
        .DEPTH (VCOUNT),
        .AW    (AW),
        .DW    (HEIGHT_W)
    ) u_vram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_vertex_index)),
        .i_wdata (i_height_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // ------------------------------------------------------------------
    // Shared multiply-accumulate. Read data is registered, so each corner
    // arrives in the state after its address: the base corner in S_RD_A,
    // corner A in S_RD_B and corner B in S_MUL_B.
    // ------------------------------------------------------------------
    t_mac_ctrl                  mac_ctrl;
    logic [WEIGHT_W-1:0]        mac_weight;
    logic signed [HEIGHT_W-1:0] mac_height;

    always_comb begin
        mac_ctrl       = '0;
        mac_ctrl.load  = (r_state == S_RD_A);
        mac_ctrl.mul   = (r_state == S_RD_B) || (r_state == S_MUL_B);
        mac_ctrl.accum = (r_state == S_MUL_B) || (r_state == S_ACC_B);
        mac_weight     = (r_state == S_MUL_B) ? r_w2 : r_w1;
    end

    hts_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_shift  (r_tile_shift),
        .i_weight (mac_weight),
        .i_sample ($signed(rd_data)),
        .o_height (mac_height)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer && (i_operation == OP_QUERY)) begin
                    n_state = S_RANGE;
                end
            end
            S_RANGE: begin
                n_state = pos_in_range ? S_RD_BASE : S_DONE;
            end
            S_RD_BASE: n_state = S_RD_A;
            S_RD_A:    n_state = S_RD_B;
            S_RD_B:    n_state = S_MUL_B;
            S_MUL_B:   n_state = S_ACC_B;
            S_ACC_B:   n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register: filled when a query finishes and the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_height   <= r_oor ? OOR_HEIGHT : mac_height;
            r_in_range <= !r_oor;
        end
    end

`ifndef SYNTH
    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_operation == OP_QUERY)) |=> (r_state == S_RANGE))
        else $error("query transfer did not start the sequencer");

    a_write_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && (i_operation == OP_WRITE)) |=> (r_state == S_IDLE))
        else $error("write transfer left the idle state");

    a_done_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && out_free) |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("finished query did not reach the output register");

    a_oor_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_in_range) |-> (r_height == OOR_HEIGHT))
        else $error("out of range result carries a wrong height");

    a_range_to_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RANGE) && pos_in_range) |=> (r_state == S_RD_BASE) && !r_oor)
        else $error("in range query did not go on to the corner reads");
`endif

endmodule

`default_nettype wire

FILE: rtl/hts_vram.sv
// ----------------------------------------------------------------------------
// hts_vram
// Vertex height memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_vram #(
    parameter int DEPTH = 289,
    parameter int AW    = 9,
    parameter int DW    = 24
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/hts_mac.sv
// ----------------------------------------------------------------------------
// hts_mac
// Shared multiply-accumulate unit for the triangle interpolation sum.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_mac (
    input  logic                                i_clk,
    input  hts_pkg::t_mac_ctrl                  i_ctrl,
    input  logic [hts_pkg::SHIFT_W-1:0]         i_shift,
    input  logic [hts_pkg::WEIGHT_W-1:0]        i_weight,
    input  logic signed [hts_pkg::HEIGHT_W-1:0] i_sample,
    output logic signed [hts_pkg::HEIGHT_W-1:0] o_height
);

    import hts_pkg::*;

    logic signed [HEIGHT_W-1:0] r_base;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    r_prod;
    logic signed [HEIGHT_W:0]   diff;
    logic signed [WEIGHT_W:0]   weight_s;
    logic signed [ACC_W-1:0]    product;
    logic signed [ACC_W-1:0]    half;
    logic signed [ACC_W-1:0]    rounded;
    logic signed [ACC_W-1:0]    scaled;

    assign diff     = $signed({i_sample[HEIGHT_W-1], i_sample})
                    - $signed({r_base[HEIGHT_W-1], r_base});
    assign weight_s = $signed({1'b0, i_weight});
    assign product  = ACC_W'(weight_s * diff);

    // Round half up: add half a tile edge, then floor by the tile shift.
    assign half     = $signed((ACC_W'(1) << i_shift) >> 1);
    assign rounded  = r_acc + half;
    assign scaled   = rounded >>> i_shift;
    assign o_height = scaled[HEIGHT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_base <= i_sample;
            r_acc  <= $signed(ACC_W'(i_sample)) <<< i_shift;
        end else if (i_ctrl.accum) begin
            r_acc  <= r_acc + r_prod;
        end
        if (i_ctrl.mul) begin
            r_prod <= product;
        end
    end

endmodule

`default_nettype wire

FILE: dv/heightmap_triangle_height_sampler_test.sv
// ----------------------------------------------------------------------------
// heightmap_triangle_height_sampler_test
// Self-checking bench for the terrain height sampler. The vertex grid is
// loaded completely, then directed and random vertex writes and height queries
// run under several sector placements and tile sizes. Each query's height and
// range flag are predicted here and compared with the block's results in order.
// ----------------------------------------------------------------------------
module heightmap_triangle_height_sampler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hts_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int TILES          = TILES_DEFAULT;
    localparam int VERTS          = TILES + 1;
    localparam int VERT_COUNT     = VERTS * VERTS;
    localparam int IDLE_PCT       = 22;
    // A little margin lets the block fall quiet before a register is changed
    // or the run is closed.
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    // The receiver holds off once, after this many results, for this long.
    localparam int HOLD_AT        = 250;
    localparam int HOLD_CYCLES    = 300;
    // The sender pauses once, after this many input transfers, until the
    // block has delivered every outstanding result.
    localparam int DRAIN_AT       = 1000;
    // The port has room for a fourth register index that the block ignores.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 24'sh7FFFFF;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = -24'sh800000;

    typedef struct {
        logic                       op;
        logic [INDEX_W-1:0]         index;
        logic signed [HEIGHT_W-1:0] value;
        logic signed [POS_W-1:0]    qx;
        logic signed [POS_W-1:0]    qz;
    } t_probe;

    typedef struct {
        logic signed [HEIGHT_W-1:0] height;
        logic                       in_range;
    } t_height_reply;

    // Every input of the block starts at a known value.
    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          i_in_valid     = 1'b0;
    logic                          i_operation    = OP_WRITE;
    logic [INDEX_W-1:0]            i_vertex_index = '0;
    logic signed [HEIGHT_W-1:0]    i_height_value = '0;
    logic signed [POS_W-1:0]       i_query_x      = '0;
    logic signed [POS_W-1:0]       i_query_z      = '0;
    logic                          i_out_ready    = 1'b0;
    logic                          i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]          i_cfg_index    = CFG_ORIGIN_X;
    logic [CFG_DATA_W-1:0]         i_cfg_data     = '0;
    logic                          o_in_ready;
    logic                          o_out_valid;
    logic signed [HEIGHT_W-1:0]    o_height;
    logic                          o_in_range;
    logic                          o_cfg_ready;

    heightmap_triangle_height_sampler #(
        .TILES_PER_SIDE(TILES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_operation    (i_operation),
        .i_vertex_index (i_vertex_index),
        .i_height_value (i_height_value),
        .i_query_x      (i_query_x),
        .i_query_z      (i_query_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_height       (o_height),
        .o_in_range     (o_in_range),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Bench copy of the sector registers and of the vertex grid. The registers
    // start at their reset values and follow each configuration transfer.
    longint                     sector_x0  = 0;
    longint                     sector_z0  = 0;
    int                         tile_log2  = TILE_SHIFT_RESET;
    logic signed [HEIGHT_W-1:0] grid_height [VERT_COUNT];

    t_probe        probe_fifo[$];   // items waiting to be offered
    t_height_reply reply_fifo[$];   // predicted results, oldest first
    t_probe        held_probe;      // the item currently on the input port

    int  probes_taken    = 0;
    int  replies_checked = 0;
    int  errors          = 0;
    int  hold_left       = 0;
    bit  hold_used       = 1'b0;
    bit  draining        = 1'b0;
    bit  drain_used      = 1'b0;
    bit  calm            = 1'b0;   // when set, neither side idles
    int  quiet_cycles    = 0;

    // ------------------------------------------------------------------------
    // Height prediction
    // ------------------------------------------------------------------------

    function automatic longint grid_at(longint col, longint row);
        return longint'(grid_height[col + row * VERTS]);
    endfunction

    // Interpolates the height under a world point from the bench grid. The
    // sector is split by the tile size into tiles; grid columns run mirrored
    // in x, so world tile cx lies between columns TILES-cx (low x) and
    // TILES-1-cx (high x).
    function automatic t_height_reply sample_height(t_probe p);
        t_height_reply r;
        longint lx, lz, cx, cz, span, fx, fz, col;
        longint h00, h10, h01, h11, num, h;
        lx = longint'(p.qx) - sector_x0;
        lz = longint'(p.qz) - sector_z0;
        cx = lx >>> tile_log2;
        cz = lz >>> tile_log2;
        if (cx < 0 || cx >= TILES || cz < 0 || cz >= TILES) begin
            r.height   = OOR_HEIGHT;
            r.in_range = 1'b0;
            return r;
        end
        span = longint'(1) << tile_log2;
        fx   = lx - (cx << tile_log2);
        fz   = lz - (cz << tile_log2);
        col  = TILES - 1 - cx;
        h00  = grid_at(col + 1, cz);
        h10  = grid_at(col, cz);
        h01  = grid_at(col + 1, cz + 1);
        h11  = grid_at(col, cz + 1);
        // The diagonal itself belongs to the low-corner triangle.
        if (fx + fz > span) begin
            num = h11 * span + (span - fx) * (h01 - h11) + (span - fz) * (h10 - h11);
        end else begin
            num = h00 * span + fx * (h10 - h00) + fz * (h01 - h00);
        end
        // Divide by the tile edge, rounding half up.
        h = (num + (span >>> 1)) >>> tile_log2;
        r.height   = h[HEIGHT_W-1:0];
        r.in_range = 1'b1;
        return r;
    endfunction

    // Applies one accepted item: a write updates the grid (indexes past the
    // grid are dropped), a query adds its predicted result.
    task automatic take_probe(t_probe p);
        if (p.op == OP_WRITE) begin
            if (p.index < VERT_COUNT) begin
                grid_height[p.index] = p.value;
            end
        end else begin
            reply_fifo.insert(reply_fifo.size(), sample_height(p));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------------

    // Fields that the operation does not use still carry random values.
    function automatic t_probe random_probe(logic op);
        t_probe p;
        p.op    = op;
        p.index = INDEX_W'($urandom);
        p.value = HEIGHT_W'($urandom);
        p.qx    = $urandom;
        p.qz    = $urandom;
        return p;
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] pick_height();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return HEIGHT_MAX;
        end else if (r < 10) begin
            return HEIGHT_MIN;
        end
        return HEIGHT_W'($urandom);
    endfunction

    // Mostly vertices of the grid, now and then an index past its end.
    function automatic int pick_index();
        if ($urandom_range(0, 99) < 5) begin
            return $urandom_range(VERT_COUNT, (1 << INDEX_W) - 1);
        end
        return $urandom_range(0, VERT_COUNT - 1);
    endfunction

    task automatic push_write(int idx, logic signed [HEIGHT_W-1:0] v);
        t_probe p;
        p       = random_probe(OP_WRITE);
        p.index = INDEX_W'(idx);
        p.value = v;
        probe_fifo.insert(probe_fifo.size(), p);
    endtask

    task automatic push_raw_query(logic [POS_W-1:0] qx, logic [POS_W-1:0] qz);
        t_probe p;
        p    = random_probe(OP_QUERY);
        p.qx = qx;
        p.qz = qz;
        probe_fifo.insert(probe_fifo.size(), p);
    endtask

    // Query at an offset from the sector's low corner. The world position
    // wraps to 32 bits, and the prediction follows the wrapped position.
    task automatic push_local_query(longint lx, longint lz);
        longint wx, wz;
        wx = sector_x0 + lx;
        wz = sector_z0 + lz;
        push_raw_query(wx[POS_W-1:0], wz[POS_W-1:0]);
    endtask

    // One local coordinate: mostly inside the sector, sometimes on a tile
    // boundary, sometimes just outside either end.
    function automatic longint aim_axis();
        longint span, whole;
        int     r;
        span  = longint'(1) << tile_log2;
        whole = TILES * span;
        r     = $urandom_range(0, 99);
        if (r < 6) begin
            return -longint'($urandom_range(1, 3));
        end else if (r < 12) begin
            return whole + $urandom_range(0, 2);
        end else if (r < 15) begin
            return whole - 1;
        end else if (r < 22) begin
            return $urandom_range(0, TILES - 1) * span;
        end
        return $urandom_range(0, TILES - 1) * span + (longint'($urandom) & (span - 1));
    endfunction

    task automatic push_aimed_query();
        longint span, lx, lz, fx;
        span = longint'(1) << tile_log2;
        lx   = aim_axis();
        lz   = aim_axis();
        // Now and then put the point exactly on the tile's diagonal.
        if ($urandom_range(0, 99) < 15 && lx >= 0 && lx < TILES * span) begin
            fx = lx & (span - 1);
            lz = $urandom_range(0, TILES - 1) * span + ((span - fx) & (span - 1));
        end
        push_local_query(lx, lz);
    endtask

    // Random traffic: writes, queries with arbitrary positions, and mostly
    // queries aimed at the sector.
    task automatic queue_mixed(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                push_write(pick_index(), pick_height());
            end else if (r < 25) begin
                push_raw_query($urandom, $urandom);
            end else begin
                push_aimed_query();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------

    // One register transfer, started at a clock edge. Valid is left high so
    // that back-to-back writes never lower and raise it in the same step.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            CFG_ORIGIN_X:   sector_x0 = longint'($signed(data));
            CFG_ORIGIN_Z:   sector_z0 = longint'($signed(data));
            CFG_TILE_SHIFT: tile_log2 = int'(data[SHIFT_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic place_sector(logic [CFG_DATA_W-1:0] x0, logic [CFG_DATA_W-1:0] z0,
                                int shift, bit poke_unused);
        write_reg(CFG_ORIGIN_X, x0);
        write_reg(CFG_ORIGIN_Z, z0);
        write_reg(CFG_TILE_SHIFT, CFG_DATA_W'(shift));
        if (poke_unused) begin
            write_reg(CFG_UNUSED, $urandom);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Returns once every item has been offered and every result has come,
    // plus a settling margin since a write leaves nothing to wait for.
    task automatic wait_drained();
        while (probe_fifo.size() != 0 || i_in_valid || reply_fifo.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: offers queued items. A new item is picked only when the
    // port is empty or its item transfers at this edge, so valid and payload
    // hold steady while the block stalls.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                take_probe(held_probe);
                probes_taken++;
            end
            // One pause that lets the block run completely dry.
            if (!drain_used && probes_taken >= DRAIN_AT) begin
                draining   = 1'b1;
                drain_used = 1'b1;
            end
            if (draining && reply_fifo.size() == 0) begin
                draining = 1'b0;
            end
            if (!i_in_valid || o_in_ready) begin
                if (probe_fifo.size() != 0 && !draining &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    held_probe     = probe_fifo.pop_front();
                    i_in_valid     <= 1'b1;
                    i_operation    <= held_probe.op;
                    i_vertex_index <= held_probe.index;
                    i_height_value <= held_probe.value;
                    i_query_x      <= held_probe.qx;
                    i_query_z      <= held_probe.qz;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: checks each result transfer against the oldest
    // prediction and throttles the ready line. Once, it holds off long enough
    // for the output register and the input side to back up.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (reply_fifo.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: height %0d in_range %0b",
                                 o_height, o_in_range);
                    end
                end else begin
                    t_height_reply want;
                    want = reply_fifo.pop_front();
                    if (o_height !== want.height || o_in_range !== want.in_range) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result %0d: height expected %0d got %0d, ",
                                     replies_checked, want.height, o_height,
                                     "in_range expected %0b got %0b",
                                     want.in_range, o_in_range);
                        end
                    end
                end
                replies_checked++;
            end
            if (!hold_used && replies_checked >= HOLD_AT) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: the run is abandoned after too many cycles without any
    // transfer on any channel.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset placement: origin at zero, 1024-unit tiles. Every vertex is
        // loaded first so that no query ever reads an unwritten entry.
        for (int v = 0; v < VERT_COUNT; v++) begin
            push_write(v, pick_height());
        end

        // Writes past the end of the grid must leave it untouched.
        push_write((1 << INDEX_W) - 1, HEIGHT_MAX);
        push_write(VERT_COUNT, HEIGHT_MIN);

        // Extreme heights on the corners of world tile (3,7); its low-x
        // column in the mirrored grid is 13 and its high-x column 12.
        push_write(13 + 7 * VERTS, HEIGHT_MAX);
        push_write(12 + 7 * VERTS, HEIGHT_MIN);
        push_write(13 + 8 * VERTS, HEIGHT_MIN);
        push_write(12 + 8 * VERTS, HEIGHT_MAX);
        push_local_query(3 * 1024, 7 * 1024);
        push_local_query(3 * 1024 + 512, 7 * 1024 + 512);      // on the diagonal
        push_local_query(3 * 1024 + 300, 7 * 1024 + 724);      // on the diagonal
        push_local_query(3 * 1024 + 301, 7 * 1024 + 724);      // just past it
        push_local_query(3 * 1024 + 1023, 7 * 1024 + 1023);

        // Sector corners and the points just outside each bound.
        push_local_query(0, 0);
        push_local_query(-1, 0);
        push_local_query(0, -1);
        push_local_query(16383, 16383);
        push_local_query(16384, 0);
        push_local_query(0, 16384);
        push_local_query(16383, 5000);
        push_raw_query(32'h7FFF_FFFF, 32'h8000_0000);
        push_raw_query(32'h8000_0000, 32'h7FFF_FFFF);

        queue_mixed(150);
        wait_drained();

        // Sector at the most negative x and near the top of z, with the
        // unused register index written as well.
        place_sector(32'h8000_0000, 32'h7FFF_0000, 12, 1'b1);
        queue_mixed(180);
        wait_drained();

        // Unit tiles, random placement, and no idling on either side.
        place_sector($urandom, $urandom, 0, 1'b0);
        calm <= 1'b1;
        queue_mixed(180);
        wait_drained();
        calm <= 1'b0;

        // Largest tile shift: the sector covers eight times the 32-bit range.
        place_sector(32'h8000_0000, 32'h8000_0000, 31, 1'b0);
        queue_mixed(150);
        wait_drained();

        // Origin at the most positive value: almost everything falls outside.
        place_sector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 20, 1'b0);
        queue_mixed(60);
        wait_drained();

        place_sector($urandom, $urandom, $urandom_range(0, 20), 1'b0);
        queue_mixed(200);
        wait_drained();

        place_sector($urandom, $urandom, 8, 1'b0);
        queue_mixed(220);
        wait_drained();

        // Back to the reset placement.
        place_sector('0, '0, TILE_SHIFT_RESET, 1'b0);
        queue_mixed(100);
        wait_drained();

        errors += reply_fifo.size();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
